// ===== rtl/jsp_pkg.sv =====
// Package for the stream header parser: parse phases, codes, widths.
// No dependencies; used by the top level and the checker by scoped names.
package jsp_pkg;

  localparam int unsigned MaxSegmentsDef = 64;
  localparam int unsigned IdxW = 6;
  localparam int unsigned EntryW = 32 + IdxW;
  localparam int unsigned OutDataW = 184;

  typedef enum logic [12:0] {
    PH_ID       = 13'b0000000000001,
    PH_FFLAGS   = 13'b0000000000010,
    PH_FPAGES   = 13'b0000000000100,
    PH_SNUM     = 13'b0000000001000,
    PH_SFLAGS   = 13'b0000000010000,
    PH_SRTS     = 13'b0000000100000,
    PH_SRTSLONG = 13'b0000001000000,
    PH_SKIP     = 13'b0000010000000,
    PH_SPAGE    = 13'b0000100000000,
    PH_SLEN     = 13'b0001000000000,
    PH_BODY     = 13'b0010000000000,
    PH_EOF      = 13'b0100000000000,
    PH_ERR      = 13'b1000000000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FILE = 2'd0,
    KIND_SEG  = 2'd1,
    KIND_BODY = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  localparam logic [1:0] ERR_BAD_ID  = 2'd0;
  localparam logic [1:0] ERR_GARBAGE = 2'd1;
  localparam logic [1:0] ERR_FULL    = 2'd2;

  localparam logic [5:0] SEG_TYPE_EOF = 6'd51;
  localparam logic [2:0] LONG_FORM    = 3'b111;

  function automatic logic [7:0] file_id_byte(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0: r = 8'h97;
      3'd1: r = 8'h4a;
      3'd2: r = 8'h42;
      3'd3: r = 8'h32;
      3'd4: r = 8'h0d;
      3'd5: r = 8'h0a;
      3'd6: r = 8'h1a;
      default: r = 8'h0a;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/jbig2_stream_header_parser.sv =====
// Top level of the stream header parser: byte-wise parse state machine,
// output register and the stored body-length table. Uses jsp_pkg, jsp_ram.
//
//  channel | dir | words                                 | marks
//  in_     | in  | one stream byte                       | -
//  out_    | out | file info, header, body byte or error | tlast = end of body
//  cfg_    | in  | embedded_mode                         | write enable
//
// A result, if any, from a taken byte shows in the output register the next
// cycle. in_tready drops only while a result waits there.
// Synchronous active-low reset; the table of stored lengths needs no clear.
// Only headers with a nonzero length enter the table, with their position,
// so random-order bodies follow each other with no gap between them.
module jbig2_stream_header_parser #(
  parameter int unsigned MAX_SEGMENTS = jsp_pkg::MaxSegmentsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,   // embedded_mode
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,      // data_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata low to high: seg_num, segment_flags, referred_count,
  // page_assoc, seg_length, page_count, segment_index, body_byte,
  // error_code, zero fill
  output logic [jsp_pkg::OutDataW-1:0]  out_tdata,
  output logic [1:0]                    out_tuser,     // kind
  output logic                          out_tlast      // last_of_segment
);

  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned RD = (MAX_SEGMENTS > 1) ? MAX_SEGMENTS : 2;

  // state
  jsp_pkg::phase_t phase_r, phase_nxt;
  logic        started_r, random_r, random_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] snum_r, snum_nxt, page_r, page_nxt, len_r, len_nxt, pages_r, pages_nxt;
  logic [7:0]  hflags_r, hflags_nxt, fflags_r, fflags_nxt;
  logic [28:0] refc_r, refc_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [CW-1:0] stored_r, stored_nxt, nz_r, nz_nxt, cur_r, cur_nxt;

  // output register
  logic [1:0]  kind_nxt, ecode_nxt;
  logic [31:0] o_num_nxt, o_page_nxt, o_len_nxt, o_pages_nxt;
  logic [7:0]  o_flags_nxt, o_body_nxt;
  logic [28:0] o_refc_nxt;
  logic [5:0]  o_idx_nxt;
  logic        o_last_nxt, o_valid_nxt;
  logic [jsp_pkg::OutDataW-1:0] tdata_nxt;

  // table
  logic                      wr_en;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [jsp_pkg::EntryW-1:0] wr_data, ram_q, byp_data_r, entry;
  logic                      byp_r;

  logic       in_fire;
  logic [7:0] b;
  logic [31:0] retain;
  logic [28:0] refc_long;
  logic [31:0] ent_len;
  logic [5:0]  ent_idx;
  logic [CW-1:0] nz_after;

  assign in_tready = !out_tvalid || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;

  assign entry   = byp_r ? byp_data_r : ram_q;
  assign ent_len = entry[31:0];
  assign ent_idx = entry[jsp_pkg::EntryW-1:32];
  assign rd_addr = cur_nxt[AW-1:0];

  jsp_ram #(.WIDTH(jsp_pkg::EntryW), .DEPTH(RD)) u_len_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // next state and result for one byte
  always_comb begin
    phase_nxt  = phase_r;
    random_nxt = random_r;
    cnt_nxt    = cnt_r;
    snum_nxt   = snum_r;
    page_nxt   = page_r;
    len_nxt    = len_r;
    pages_nxt  = pages_r;
    hflags_nxt = hflags_r;
    fflags_nxt = fflags_r;
    refc_nxt   = refc_r;
    err_nxt    = err_r;
    stored_nxt = stored_r;
    nz_nxt     = nz_r;
    cur_nxt    = cur_r;
    wr_en      = 1'b0;
    wr_addr    = nz_r[AW-1:0];
    wr_data    = {stored_r[5:0], len_r};
    o_valid_nxt = 1'b0;
    kind_nxt    = jsp_pkg::KIND_FILE;
    ecode_nxt   = 2'd0;
    o_num_nxt   = '0;
    o_page_nxt  = '0;
    o_len_nxt   = '0;
    o_pages_nxt = '0;
    o_flags_nxt = '0;
    o_body_nxt  = '0;
    o_refc_nxt  = '0;
    o_idx_nxt   = '0;
    o_last_nxt  = 1'b0;
    refc_long   = {refc_r[20:0], b};
    nz_after    = nz_r;
    retain = '0;

    if (in_fire) begin
      case (phase_r)
        jsp_pkg::PH_ID: begin
          if (b != jsp_pkg::file_id_byte(cnt_r[2:0])) begin
            phase_nxt = jsp_pkg::PH_ERR;
            err_nxt = jsp_pkg::ERR_BAD_ID;
            o_valid_nxt = 1'b1;
            kind_nxt = jsp_pkg::KIND_ERR;
            ecode_nxt = jsp_pkg::ERR_BAD_ID;
          end else if (cnt_r[2:0] == 3'd7) begin
            cnt_nxt = '0;
            phase_nxt = jsp_pkg::PH_FFLAGS;
          end else begin
            cnt_nxt = cnt_r + 32'd1;
          end
        end
        jsp_pkg::PH_FFLAGS: begin
          fflags_nxt = b;
          random_nxt = !b[0];
          pages_nxt = '0;
          cnt_nxt = '0;
          if (b[1]) begin
            o_valid_nxt = 1'b1;
            kind_nxt = jsp_pkg::KIND_FILE;
            o_flags_nxt = b;
            phase_nxt = jsp_pkg::PH_SNUM;
          end else begin
            phase_nxt = jsp_pkg::PH_FPAGES;
          end
        end
        jsp_pkg::PH_FPAGES: begin
          pages_nxt = {pages_r[23:0], b};
          if (cnt_r[1:0] == 2'd3) begin
            cnt_nxt = '0;
            o_valid_nxt = 1'b1;
            kind_nxt = jsp_pkg::KIND_FILE;
            o_flags_nxt = fflags_r;
            o_pages_nxt = {pages_r[23:0], b};
            phase_nxt = jsp_pkg::PH_SNUM;
          end else begin
            cnt_nxt = cnt_r + 32'd1;
          end
        end
        jsp_pkg::PH_SNUM: begin
          snum_nxt = {snum_r[23:0], b};
          if (cnt_r[1:0] == 2'd3) begin
            cnt_nxt = '0;
            phase_nxt = jsp_pkg::PH_SFLAGS;
          end else begin
            cnt_nxt = cnt_r + 32'd1;
          end
        end
        jsp_pkg::PH_SFLAGS: begin
          hflags_nxt = b;
          phase_nxt = jsp_pkg::PH_SRTS;
        end
        jsp_pkg::PH_SRTS: begin
          if (b[7:5] == jsp_pkg::LONG_FORM) begin
            refc_nxt = {24'd0, b[4:0]};
            cnt_nxt = '0;
            phase_nxt = jsp_pkg::PH_SRTSLONG;
          end else begin
            refc_nxt = {26'd0, b[7:5]};
            // short form: no retention bytes, up to 6 references of 1, 2 or 4 bytes
            if (snum_r <= 32'd256) cnt_nxt = {29'd0, b[7:5]};
            else if (snum_r <= 32'd65536) cnt_nxt = {28'd0, b[7:5], 1'b0};
            else cnt_nxt = {27'd0, b[7:5], 2'b00};
            page_nxt = '0;
            phase_nxt = (b[7:5] != 3'd0) ? jsp_pkg::PH_SKIP : jsp_pkg::PH_SPAGE;
          end
        end
        jsp_pkg::PH_SRTSLONG: begin
          refc_nxt = refc_long;
          if (cnt_r[1:0] == 2'd2) begin
            // retention ceil((count+1)/8) plus reference bytes; never zero
            retain = {6'd0, refc_long[28:3]} + 32'd1;
            if (snum_r <= 32'd256) cnt_nxt = retain + {3'd0, refc_long};
            else if (snum_r <= 32'd65536) cnt_nxt = retain + {2'd0, refc_long, 1'b0};
            else cnt_nxt = retain + {1'b0, refc_long, 2'b00};
            page_nxt = '0;
            phase_nxt = jsp_pkg::PH_SKIP;
          end else begin
            cnt_nxt = cnt_r + 32'd1;
          end
        end
        jsp_pkg::PH_SKIP: begin
          cnt_nxt = cnt_r - 32'd1;
          if (cnt_r == 32'd1) phase_nxt = jsp_pkg::PH_SPAGE;
        end
        jsp_pkg::PH_SPAGE: begin
          page_nxt = {page_r[23:0], b};
          if (!hflags_r[6] || cnt_r[1:0] == 2'd3) begin
            cnt_nxt = '0;
            len_nxt = '0;
            phase_nxt = jsp_pkg::PH_SLEN;
          end else begin
            cnt_nxt = cnt_r + 32'd1;
          end
        end
        jsp_pkg::PH_SLEN: begin
          len_nxt = {len_r[23:0], b};
          if (cnt_r[1:0] != 2'd3) begin
            cnt_nxt = cnt_r + 32'd1;
          end else if (random_r && stored_r >= CW'(MAX_SEGMENTS)) begin
            phase_nxt = jsp_pkg::PH_ERR;
            err_nxt = jsp_pkg::ERR_FULL;
            o_valid_nxt = 1'b1;
            kind_nxt = jsp_pkg::KIND_ERR;
            ecode_nxt = jsp_pkg::ERR_FULL;
          end else begin
            cnt_nxt = '0;
            o_valid_nxt = 1'b1;
            kind_nxt = jsp_pkg::KIND_SEG;
            o_num_nxt = snum_r;
            o_flags_nxt = hflags_r;
            o_refc_nxt = refc_r;
            o_page_nxt = page_r;
            o_len_nxt = {len_r[23:0], b};
            if (random_r) begin
              o_idx_nxt = stored_r[5:0];
              stored_nxt = stored_r + CW'(1);
              // only bodies with bytes enter the table
              if ({len_r[23:0], b} != 32'd0) begin
                wr_en = 1'b1;
                wr_data = {stored_r[5:0], len_r[23:0], b};
                nz_after = nz_r + CW'(1);
                nz_nxt = nz_after;
              end
              if (hflags_r[5:0] == jsp_pkg::SEG_TYPE_EOF) begin
                cur_nxt = '0;
                phase_nxt = (nz_after != '0) ? jsp_pkg::PH_BODY : jsp_pkg::PH_EOF;
              end else begin
                phase_nxt = jsp_pkg::PH_SNUM;
              end
            end else begin
              phase_nxt = ({len_r[23:0], b} != 32'd0) ? jsp_pkg::PH_BODY
                                                      : jsp_pkg::PH_SNUM;
            end
          end
        end
        jsp_pkg::PH_BODY: begin
          o_valid_nxt = 1'b1;
          kind_nxt = jsp_pkg::KIND_BODY;
          o_body_nxt = b;
          o_idx_nxt = random_r ? ent_idx : 6'd0;
          if ((cnt_r + 32'd1) >= (random_r ? ent_len : len_r)) begin
            o_last_nxt = 1'b1;
            cnt_nxt = '0;
            if (random_r) begin
              cur_nxt = cur_r + CW'(1);
              phase_nxt = ((cur_r + CW'(1)) < nz_r) ? jsp_pkg::PH_BODY
                                                    : jsp_pkg::PH_EOF;
            end else begin
              phase_nxt = jsp_pkg::PH_SNUM;
            end
          end else begin
            cnt_nxt = cnt_r + 32'd1;
          end
        end
        jsp_pkg::PH_EOF: begin
          phase_nxt = jsp_pkg::PH_ERR;
          err_nxt = jsp_pkg::ERR_GARBAGE;
          o_valid_nxt = 1'b1;
          kind_nxt = jsp_pkg::KIND_ERR;
          ecode_nxt = jsp_pkg::ERR_GARBAGE;
        end
        default: begin
          o_valid_nxt = 1'b1;
          kind_nxt = jsp_pkg::KIND_ERR;
          ecode_nxt = err_r;
        end
      endcase
    end else if (cfg_wr_en && !started_r) begin
      // starting phase follows the mode until the first byte
      phase_nxt = cfg_wr_data ? jsp_pkg::PH_SNUM : jsp_pkg::PH_ID;
    end
    tdata_nxt = {3'd0, ecode_nxt, o_body_nxt, o_idx_nxt, o_pages_nxt, o_len_nxt,
                 o_page_nxt, o_refc_nxt, o_flags_nxt, o_num_nxt};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= jsp_pkg::PH_ID;
      started_r  <= 1'b0;
      random_r   <= 1'b0;
      cnt_r      <= '0;
      err_r      <= 2'd0;
      stored_r   <= '0;
      nz_r       <= '0;
      cur_r      <= '0;
      out_tvalid <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      if (in_fire) started_r <= 1'b1;
      random_r   <= random_nxt;
      cnt_r      <= cnt_nxt;
      err_r      <= err_nxt;
      stored_r   <= stored_nxt;
      nz_r       <= nz_nxt;
      cur_r      <= cur_nxt;
      byp_r      <= wr_en && (wr_addr == rd_addr);
      if (in_tready) out_tvalid <= o_valid_nxt;
    end
  end

  // header fields and output payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snum_r   <= '0;
      page_r   <= '0;
      len_r    <= '0;
      pages_r  <= '0;
      hflags_r <= '0;
      fflags_r <= '0;
      refc_r   <= '0;
    end else begin
      snum_r   <= snum_nxt;
      page_r   <= page_nxt;
      len_r    <= len_nxt;
      pages_r  <= pages_nxt;
      hflags_r <= hflags_nxt;
      fflags_r <= fflags_nxt;
      refc_r   <= refc_nxt;
    end
    byp_data_r <= wr_data;
    if (in_tready && o_valid_nxt) begin
      out_tdata <= tdata_nxt;
      out_tuser <= kind_nxt;
      out_tlast <= o_last_nxt;
    end
  end

endmodule

// ===== rtl/jsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module jsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/jsp_checker.sv =====
// Port-level checker for the stream header parser, bound to the top level.
// Uses jsp_pkg for kind and error codes.
module jsp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [183:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  // a waiting word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // input side only stalls behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // end mark only on body bytes
  a_last_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == jsp_pkg::KIND_BODY)
    else $error("end mark on non-body word");

  // error code in range
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == jsp_pkg::KIND_ERR |-> out_tdata[180:179] != 2'd3)
    else $error("bad error code");

endmodule

bind jbig2_stream_header_parser jsp_checker u_jsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
